// ----- src/pli_pkg.sv -----
// Shared types and constants for the piecewise linear interpolator.
package pli_pkg;

  localparam int PLI_MAX_POINTS = 16;
  localparam int PLI_CFG_W      = 5;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } pli_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BELOW = 2'd1,
    ST_ABOVE = 2'd2,
    ST_ORDER = 2'd3
  } pli_status_t;

  typedef struct packed {
    logic               opcode;
    logic [3:0]         point_index;
    logic signed [15:0] x_value;
    logic signed [15:0] y_value;
    logic               restart;
  } pli_item_t;

  typedef struct packed {
    logic signed [15:0] result_value;
    logic [1:0]         status;
  } pli_result_t;

  // queue entry: item plus what the front found out about it
  typedef struct packed {
    logic      is_eval;
    pli_item_t item;
  } pli_cmd_t;

endpackage

// ----- src/pli_front.sv -----
// Front end: accepts transactions, classifies them and queues them for the back end.
module pli_front import pli_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  pli_item_t item,
  output logic      busy,
  output logic      q_valid,
  output pli_cmd_t  q_head,
  input  logic      q_pop
);

  pli_cmd_t   slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign busy    = (count == 2'd2);
  assign push    = start && !busy;
  assign pop     = q_pop && q_valid;
  assign q_valid = (count != 2'd0);
  assign q_head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].is_eval <= (item.opcode == OP_EVAL);
      slots[wr_ptr].item    <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- src/pli_back.sv -----
// Back end: breakpoint table, segment walk, fraction divider and multiplier.
module pli_back import pli_pkg::*; #(
  parameter int MAX_POINTS = PLI_MAX_POINTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [PLI_CFG_W-1:0] points_in_use,
  input  logic                 q_valid,
  input  pli_cmd_t             q_head,
  output logic                 q_pop,
  output logic                 done,
  output pli_result_t          result
);

  localparam int IW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_CHKLO, S_WALK, S_DIV, S_MUL, S_OUT
  } state_t;

  state_t state;

  logic signed [15:0] mem_x [MAX_POINTS];
  logic signed [15:0] mem_y [MAX_POINTS];
  logic signed [15:0] rdx;
  logic signed [15:0] rdy;
  logic [IW-1:0]      rd_addr;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [8:0]         slot_ext;

  logic [IW-1:0]      ptr;
  logic [IW-1:0]      p;
  logic [IW-1:0]      p_start;
  logic [8:0]         n;
  logic [8:0]         n_last;
  logic signed [15:0] xq;
  logic signed [15:0] x_lo;
  logic signed [15:0] y_lo;
  logic signed [15:0] y_hi;
  logic [16:0]        den;
  logic [16:0]        rem;
  logic [17:0]        rem2;
  logic               q16;
  logic [15:0]        qlo;
  logic [3:0]         cnt;
  logic signed [35:0] prod;

  logic signed [16:0] den_c;
  logic signed [16:0] num_c;
  logic signed [16:0] dy;

  // clamp the curve length to [2, MAX_POINTS]
  always_comb begin
    if (points_in_use < 5'd2) begin
      n = 9'd2;
    end else if (9'(points_in_use) > 9'(MAX_POINTS)) begin
      n = 9'(MAX_POINTS);
    end else begin
      n = 9'(points_in_use);
    end
    n_last = n - 9'd2;
  end

  always_comb begin
    p_start = q_head.item.restart ? '0 : ptr;
    if (9'(p_start) > n_last) p_start = n_last[IW-1:0];
  end

  assign q_pop    = (state == S_IDLE);
  assign slot_ext = {5'd0, q_head.item.point_index};
  assign wr_en    = (state == S_IDLE) && q_valid && !q_head.is_eval &&
                    (slot_ext < 9'(MAX_POINTS));
  assign wr_addr  = slot_ext[IW-1:0];

  always_comb begin
    case (state)
      S_IDLE:  rd_addr = p_start;
      S_CHKLO: rd_addr = p + IW'(1);
      S_WALK:  rd_addr = p + IW'(2);
      default: rd_addr = p;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= q_head.item.x_value;
      mem_y[wr_addr] <= q_head.item.y_value;
    end
    rdx <= mem_x[rd_addr];
    rdy <= mem_y[rd_addr];
  end

  assign den_c = 17'(rdx) - 17'(x_lo);
  assign num_c = 17'(xq) - 17'(x_lo);
  assign dy    = 17'(y_hi) - 17'(y_lo);
  assign rem2  = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ptr   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid && q_head.is_eval) begin
            p     <= p_start;
            xq    <= q_head.item.x_value;
            state <= S_CHKLO;
          end
        end
        S_CHKLO: begin
          if (xq < rdx) begin
            // below the current segment start: below range or out of order
            done  <= 1'b1;
            ptr   <= p;
            if (p == '0) begin
              result.result_value <= rdy;
              result.status       <= ST_BELOW;
            end else begin
              result.result_value <= '0;
              result.status       <= ST_ORDER;
            end
            state <= S_IDLE;
          end else begin
            x_lo  <= rdx;
            y_lo  <= rdy;
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if ((9'(p) < n_last) && (xq > rdx)) begin
            p    <= p + IW'(1);
            x_lo <= rdx;
            y_lo <= rdy;
          end else begin
            ptr <= p;
            if (xq > rdx) begin
              done                <= 1'b1;
              result.result_value <= rdy;
              result.status       <= ST_ABOVE;
              state               <= S_IDLE;
            end else if (den_c <= 17'sd0) begin
              done                <= 1'b1;
              result.result_value <= y_lo;
              result.status       <= ST_OK;
              state               <= S_IDLE;
            end else begin
              y_hi <= rdy;
              den  <= den_c;
              // num <= den, so the top quotient bit is set only at x == x_hi
              if (num_c >= den_c) begin
                q16 <= 1'b1;
                rem <= num_c - den_c;
              end else begin
                q16 <= 1'b0;
                rem <= num_c;
              end
              qlo   <= '0;
              cnt   <= '0;
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (rem2 >= {1'b0, den}) begin
            rem <= 17'(rem2 - {1'b0, den});
            qlo <= {qlo[14:0], 1'b1};
          end else begin
            rem <= rem2[16:0];
            qlo <= {qlo[14:0], 1'b0};
          end
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) state <= S_MUL;
        end
        S_MUL: begin
          prod  <= 36'(18'(dy) * $signed({1'b0, q16, qlo})) + 36'sd32768;
          state <= S_OUT;
        end
        S_OUT: begin
          done                <= 1'b1;
          result.result_value <= y_lo + prod[31:16];
          result.status       <= ST_OK;
          state               <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/piecewise_linear_interpolator_top.sv -----
// Top level of the piecewise linear interpolator.
//
// Input: a transaction is taken at a clock edge with start high and busy low.
// A load (opcode 0) writes breakpoint (x_value, y_value) to slot point_index;
// an evaluate (opcode 1) interpolates at x_value, restart rewinding the
// segment pointer first. Transactions land in a two-entry queue; busy is
// high while the queue is full.
// Output: one result per evaluate, shown for one cycle with done high.
// The receiver cannot stall; results are in transaction order.
// Config: cfg_data (points_in_use) is written when cfg_valid is high;
// cfg_ready is always high. Write it only while the block is idle.
// Sequence: a load is written to the table when the back end takes it. An
// evaluate reads the first segment start (S_CHKLO), walks the segments
// (S_WALK), then runs the restoring fraction divider (S_DIV) and multiply
// and round (S_MUL, S_OUT). The single table read port and the divider set
// the evaluate time. Below-range and out-of-order results come from the
// first segment check; above-range and zero-width results come right after
// the walk. Queued transactions wait their turn.
// Reset clears the queue, the segment pointer and points_in_use (to 2);
// table contents are undefined until loaded.
module piecewise_linear_interpolator_top import pli_pkg::*; #(
  parameter int MAX_POINTS = PLI_MAX_POINTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  pli_item_t            item,
  output logic                 done,
  output pli_result_t          result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [PLI_CFG_W-1:0] cfg_data
);

  logic [PLI_CFG_W-1:0] points_in_use;
  logic                 q_valid;
  logic                 q_pop;
  pli_cmd_t             q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= PLI_CFG_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      points_in_use <= cfg_data;
    end
  end

  pli_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .item    (item),
    .busy    (busy),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop)
  );

  pli_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .points_in_use (points_in_use),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .done          (done),
    .result        (result)
  );

endmodule

// ----- src/pli_checker.sv -----
// Port-level checks for the interpolator, bound to the top level.
module pli_checker import pli_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input pli_result_t result,
  input logic        cfg_ready
);

  // the back end returns to S_IDLE after each result, so results never come back to back
  a_done_gap: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("results on consecutive cycles");

  a_reset: assert property (@(posedge clk) rst |=> (!done && !busy))
    else $error("activity right after reset");

  a_order_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_ORDER) |-> (result.result_value == 16'sd0))
    else $error("out-of-order result not zero");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config channel not ready");

endmodule

bind piecewise_linear_interpolator_top pli_checker u_pli_checker (
  .clk       (clk),
  .rst       (rst),
  .busy      (busy),
  .done      (done),
  .result    (result),
  .cfg_ready (cfg_ready)
);

// ----- dv/pli_interp_checker.sv -----
// Checker for the interpolator: predicts each evaluate result and compares it.
module pli_interp_checker import pli_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  pli_item_t            item,
  input  logic                 done,
  input  pli_result_t          result,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [PLI_CFG_W-1:0] cfg_data,
  output int                   pending,
  output int                   errors
);
  timeunit 1ns;
  timeprecision 1ps;

  int          bp_x [PLI_MAX_POINTS];
  int          bp_y [PLI_MAX_POINTS];
  int          seg_ptr;
  int          curve_points;
  pli_result_t expected_q[$];

  // returns 1 when the transaction produces a result
  function automatic bit interpolate(input pli_item_t it, output pli_result_t r);
    int     n, p, qx, x_lo, x_hi, y_lo, y_hi;
    longint den, num, frac, prod;
    r = '0;
    qx = int'($signed(it.x_value));
    if (pli_op_t'(it.opcode) == OP_LOAD) begin
      bp_x[it.point_index] = qx;
      bp_y[it.point_index] = int'($signed(it.y_value));
      return 1'b0;
    end
    n = curve_points;
    if (n < 2) n = 2;
    if (n > PLI_MAX_POINTS) n = PLI_MAX_POINTS;
    if (it.restart) seg_ptr = 0;
    if (seg_ptr > n - 2) seg_ptr = n - 2;
    p = seg_ptr;
    if (qx < bp_x[p]) begin
      if (p == 0) begin
        r.result_value = bp_y[0][15:0];
        r.status       = ST_BELOW;
      end else begin
        r.result_value = '0;
        r.status       = ST_ORDER;
      end
      return 1'b1;
    end
    while (p < n - 2 && qx > bp_x[p+1]) p++;
    seg_ptr = p;
    if (qx > bp_x[p+1]) begin
      r.result_value = bp_y[n-1][15:0];
      r.status       = ST_ABOVE;
      return 1'b1;
    end
    x_lo = bp_x[p];
    x_hi = bp_x[p+1];
    y_lo = bp_y[p];
    y_hi = bp_y[p+1];
    den  = longint'(x_hi) - longint'(x_lo);
    r.status = ST_OK;
    if (den <= 0) begin
      r.result_value = y_lo[15:0];
      return 1'b1;
    end
    num  = longint'(qx) - longint'(x_lo);
    frac = (num * 65536) / den;
    prod = (longint'(y_hi) - longint'(y_lo)) * frac + 32768;
    // arithmetic shift floors toward minus infinity
    prod = longint'(y_lo) + (prod >>> 16);
    r.result_value = prod[15:0];
    return 1'b1;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    pli_result_t exp_res;
    if (rst) begin
      seg_ptr      = 0;
      curve_points = 2;
      expected_q.delete();
      errors       = 0;
    end else begin
      if (cfg_valid && cfg_ready) curve_points = int'(cfg_data);
      if (start && !busy) begin
        if (interpolate(item, exp_res)) expected_q.insert(expected_q.size(), exp_res);
      end
      if (done) begin
        if (expected_q.size() == 0) begin
          $error("result with no evaluate outstanding: value %0d status %0d",
                 result.result_value, result.status);
          errors++;
        end else begin
          exp_res = expected_q.pop_front();
          if (result.result_value !== exp_res.result_value) begin
            $error("result_value: expected %0d, actual %0d",
                   exp_res.result_value, result.result_value);
            errors++;
          end
          if (result.status !== exp_res.status) begin
            $error("status: expected %0d, actual %0d", exp_res.status, result.status);
            errors++;
          end
        end
      end
    end
  end

endmodule

// ----- dv/piecewise_linear_interpolator_top_tb.sv -----
// Testbench top: drives breakpoint loads, queries and config writes, gives the verdict.
module piecewise_linear_interpolator_top_tb;
  import pli_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 60;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  pli_item_t            item;
  logic                 done;
  pli_result_t          result;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [PLI_CFG_W-1:0] cfg_data;
  int                   pending;
  int                   errors;
  int                   idle_cycles;
  bit                   no_gaps;

  piecewise_linear_interpolator_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  pli_interp_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data), .pending(pending), .errors(errors)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog on cycles with no transaction of any kind
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send(input pli_op_t op, input int slot, input int xv, input int yv,
                      input bit rs);
    int gap;
    pli_item_t it;
    it.opcode      = op;
    it.point_index = slot[3:0];
    it.x_value     = xv[15:0];
    it.y_value     = yv[15:0];
    it.restart     = rs;
    item  <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    gap = 0;
    if (!no_gaps) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: gap = 0;
        9:          gap = $urandom_range(10, 40);
        default:    gap = $urandom_range(1, 3);
      endcase
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // a trailing load gives no result; let the back end finish it
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_points(input int value);
    wait_idle();
    cfg_data  <= value[PLI_CFG_W-1:0];
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int rand_s16();
    return int'($signed(16'($urandom())));
  endfunction

  initial begin
    static int cfg_choices[6] = '{2, 16, 0, 1, 31, 9};
    int npts, xv, qx, step, nq;
    start     = 1'b0;
    item      = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    no_gaps   = 1'b0;
    rst       = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every slot loaded, first x above the minimum so below range exists
    for (int i = 0; i < PLI_MAX_POINTS; i++) begin
      xv = -30000 + i * 4000;
      if (i == 3) xv = -30000 + 2 * 4000;         // zero-width segment 2..3
      if (i == 15) xv = 32767;
      send(OP_LOAD, i, xv, (i % 2) ? 32767 : -32768, i[0]);
    end
    write_points(16);
    send(OP_EVAL, 0, -32768, 0, 1'b1);   // below range
    send(OP_EVAL, 0, -30000, 0, 1'b0);   // on first breakpoint
    send(OP_EVAL, 0, -29999, 0, 1'b0);
    send(OP_EVAL, 0, -22000, 0, 1'b0);   // breakpoint 2, start of the zero-width segment
    send(OP_EVAL, 0, -5001, 32767, 1'b0);
    send(OP_EVAL, 0, -20000, 0, 1'b0);   // out of order
    send(OP_EVAL, 0, 32767, 0, 1'b0);    // last breakpoint
    send(OP_EVAL, 0, -32768, 0, 1'b1);   // restart then below
    write_points(3);
    send(OP_EVAL, 0, 32767, 0, 1'b1);    // above range
    send(OP_EVAL, 0, -25000, 0, 1'b0);   // resumes at the segment left by the above-range query

    // random phases: well-formed tables with sorted queries, plus noise
    for (int ph = 0; ph < 22; ph++) begin
      no_gaps = (ph % 4 == 1);
      write_points((ph < 6) ? cfg_choices[ph] : $urandom_range(0, 31));
      npts = $urandom_range(0, 9) == 0 ? $urandom_range(2, 16) : $urandom_range(2, 6);
      xv = $urandom_range(0, 3) == 0 ? -32768 : -32768 + $urandom_range(0, 20000);
      for (int i = 0; i < PLI_MAX_POINTS; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          send(OP_LOAD, i, rand_s16(), rand_s16(), $urandom_range(0, 1));
        end else begin
          send(OP_LOAD, i, xv, rand_s16(), $urandom_range(0, 1));
          step = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 65535 / (npts + 1));
          if (xv + step <= 32767) xv = xv + step;
        end
      end
      nq = $urandom_range(30, 55);
      qx = -32768 + $urandom_range(0, 20000);
      for (int k = 0; k < nq; k++) begin
        if ($urandom_range(0, 6) == 0) begin
          send(OP_EVAL, $urandom_range(0, 15), rand_s16(), rand_s16(),
               $urandom_range(0, 1));
        end else if (k > 0 && $urandom_range(0, 14) == 0) begin
          qx = -32768 + $urandom_range(0, 30000);
          send(OP_EVAL, $urandom_range(0, 15), qx, rand_s16(), 1'b1);
        end else begin
          send(OP_EVAL, $urandom_range(0, 15), qx, rand_s16(), k == 0);
          step = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 3000);
          if (qx + step <= 32767) qx = qx + step;
        end
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
